// ===== rtl/thrd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// thrd_pkg
// Shared types and constants for the tilt-to-haptic ring drive unit.
// ---------------------------------------------------------------------------
package thrd_pkg;

    localparam int AXIS_W      = 16;
    localparam int SQ_W        = 32;
    localparam int ROOT_W      = 16;
    localparam int REM_W       = 20;
    localparam int CELLS       = ROOT_W;
    localparam int RAW_W       = 10;
    localparam int DUTY_W      = 8;
    localparam int PROD_W      = 18;
    localparam int MOTORS      = 8;
    localparam int SCALE_SH    = 6;
    localparam int IDX_W       = 2;
    localparam int DATA_W      = 10;
    localparam int LANE_STAGES = 3;

    localparam logic [RAW_W-1:0]  THRESHOLD_RST = 10'd30;
    localparam logic [DUTY_W-1:0] FLOOR_RST     = 8'd50;
    localparam logic [DUTY_W-1:0] SPAN_RST      = 8'd130;
    localparam logic [DUTY_W-1:0] BIAS_RST      = 8'd30;
    localparam logic [DUTY_W-1:0] DUTY_MAX      = 8'd255;

    typedef enum logic [IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_FLOOR     = 2'd1,
        REG_SPAN      = 2'd2,
        REG_BIAS      = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
    } sample_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_0;
        logic [DUTY_W-1:0] duty_1;
        logic [DUTY_W-1:0] duty_2;
        logic [DUTY_W-1:0] duty_3;
        logic [DUTY_W-1:0] duty_4;
        logic [DUTY_W-1:0] duty_5;
        logic [DUTY_W-1:0] duty_6;
        logic [DUTY_W-1:0] duty_7;
    } duties_t;

    typedef struct packed {
        logic [RAW_W-1:0]  threshold;
        logic [DUTY_W-1:0] floor_duty;
        logic [DUTY_W-1:0] span;
        logic [DUTY_W-1:0] bias;
    } cfg_t;

    typedef struct packed {
        logic             nz;
        logic             xneg;
        logic             yneg;
        logic [RAW_W-1:0] xs;
        logic [RAW_W-1:0] ys;
    } side_t;

    typedef struct packed {
        logic [SQ_W-1:0]   rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        side_t             side;
    } cell_t;

endpackage
`default_nettype wire

// ===== rtl/thrd_sqrt_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// thrd_sqrt_cell
// One digit step of the integer square root; hands its result to the next cell.
// ---------------------------------------------------------------------------
module thrd_sqrt_cell
    import thrd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire cell_t in_data,
    output logic       out_valid,
    output cell_t      out_data
);

    logic        valid_reg;
    cell_t       data_reg;
    cell_t       data_next;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic        ge;

    always_comb
    begin
        rem_sh    = {in_data.rem[REM_W-3:0], in_data.rad[SQ_W-1:SQ_W-2]};
        trial     = {{(REM_W-ROOT_W-2){1'b0}}, in_data.root, 2'b01};
        ge        = (rem_sh >= trial);
        data_next = in_data;
        data_next.rad  = {in_data.rad[SQ_W-3:0], 2'b00};
        data_next.rem  = ge ? (rem_sh - trial) : rem_sh;
        data_next.root = {in_data.root[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ===== rtl/thrd_duty_lane.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// thrd_duty_lane
// Maps one motor's raw strength to a PWM duty over three stages.
// ---------------------------------------------------------------------------
module thrd_duty_lane
    import thrd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic [RAW_W-1:0] raw,
    input  wire cfg_t             cfg,
    output logic [DUTY_W-1:0]     duty
);

    logic [PROD_W-1:0] prod_a_reg;
    logic              ok_a_reg;
    logic [PROD_W-1:0] prod_b_reg;
    logic [RAW_W-1:0]  q0_b_reg;
    logic              ok_b_reg;
    logic [DUTY_W-1:0] duty_reg;

    logic [PROD_W+7:0] recip;
    logic [PROD_W:0]   resid;
    logic [RAW_W:0]    quot;
    logic [RAW_W+1:0]  sum;
    logic [DUTY_W-1:0] duty_next;

    always_comb
    begin
        recip = {8'b0, prod_a_reg} + {prod_a_reg, 8'b0};
        resid = {1'b0, prod_b_reg} + {{(PROD_W-RAW_W+1){1'b0}}, q0_b_reg}
              - {1'b0, q0_b_reg, 8'b0};
        quot  = {1'b0, q0_b_reg} + {{RAW_W{1'b0}}, (resid >= (PROD_W+1)'(255))};
        sum   = {{(RAW_W+2-DUTY_W){1'b0}}, cfg.floor_duty} + {1'b0, quot};
        if (!ok_b_reg)
        begin
            duty_next = '0;
        end
        else if (sum > {{(RAW_W+2-DUTY_W){1'b0}}, DUTY_MAX})
        begin
            duty_next = DUTY_MAX;
        end
        else
        begin
            duty_next = sum[DUTY_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_a_reg <= PROD_W'(cfg.span) * PROD_W'(raw);
        ok_a_reg   <= (raw >= cfg.threshold);
        prod_b_reg <= prod_a_reg;
        q0_b_reg   <= recip[PROD_W+7:16];
        ok_b_reg   <= ok_a_reg;
        duty_reg   <= duty_next;
    end

    assign duty = duty_reg;

endmodule
`default_nettype wire

// ===== rtl/tilt_to_haptic_ring_drive_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tilt_to_haptic_ring_drive_unit
// Turns a signed X/Y tilt sample into PWM duties for a ring of eight motors.
//
// Usage:
//   Pulse start with a sample; a transaction is accepted on any edge where
//   start is high and busy is low. busy stays low: a new sample may be
//   issued every cycle.
//   done is high for exactly one cycle with all eight duties on result.
//   The receiver cannot stall, so results must be taken in that cycle.
//   Pipeline: abs/square/sum registers, 16 square-root cells (one result
//   bit per cell), a motor-select register, then the duty mapping lanes.
//   Throughput: one transaction per cycle.
//   Registers are written through wr_en/wr_index/wr_data; the user must
//   write them with no transaction in flight (the block does not enforce
//   it); they take effect at once. Reset clears all in-flight transactions
//   and loads the default threshold 30, floor 50, span 130 and bias 30.
// ---------------------------------------------------------------------------
module tilt_to_haptic_ring_drive_unit
    import thrd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sample_t           sample,
    output logic                   done,
    output duties_t                result,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_index,
    input  wire logic [DATA_W-1:0] wr_data
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;

    logic  accept;
    logic [AXIS_W-1:0] ux;
    logic [AXIS_W-1:0] uy;
    logic [AXIS_W-1:0] ax;
    logic [AXIS_W-1:0] ay;
    side_t side_next;

    logic              v0_reg;
    logic [AXIS_W-1:0] ax_reg;
    logic [AXIS_W-1:0] ay_reg;
    side_t             side0_reg;

    logic              v1_reg;
    logic [SQ_W-1:0]   sqx_reg;
    logic [SQ_W-1:0]   sqy_reg;
    side_t             side1_reg;

    logic              v2_reg;
    logic [SQ_W-1:0]   sum_reg;
    side_t             side2_reg;

    logic  cell_v [CELLS+1];
    cell_t cell_d [CELLS+1];

    logic [RAW_W-1:0] raw_next [MOTORS];
    logic [RAW_W-1:0] raw_reg  [MOTORS];
    logic             vraw_reg;
    logic [RAW_W-1:0] yf;
    logic [RAW_W-1:0] dg;
    side_t            tail;

    logic [LANE_STAGES-1:0] vlane_reg;
    logic [DUTY_W-1:0]      duty [MOTORS];
    logic [MOTORS-1:0]      nz_vec;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_THRESHOLD: cfg_next.threshold  = wr_data[RAW_W-1:0];
                REG_FLOOR:     cfg_next.floor_duty = wr_data[DUTY_W-1:0];
                REG_SPAN:      cfg_next.span       = wr_data[DUTY_W-1:0];
                REG_BIAS:      cfg_next.bias       = wr_data[DUTY_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold  <= THRESHOLD_RST;
            cfg_reg.floor_duty <= FLOOR_RST;
            cfg_reg.span       <= SPAN_RST;
            cfg_reg.bias       <= BIAS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: magnitude, squares, sum
    always_comb
    begin
        ux = sample.accel_x;
        uy = sample.accel_y;
        ax = ux[AXIS_W-1] ? (~ux + 1'b1) : ux;
        ay = uy[AXIS_W-1] ? (~uy + 1'b1) : uy;
        side_next.nz   = (ax != '0) && (ay != '0);
        side_next.xneg = ux[AXIS_W-1];
        side_next.yneg = uy[AXIS_W-1];
        side_next.xs   = RAW_W'(ax >> SCALE_SH);
        side_next.ys   = RAW_W'(ay >> SCALE_SH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            vraw_reg  <= 1'b0;
            vlane_reg <= '0;
        end
        else
        begin
            v0_reg    <= accept;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            vraw_reg  <= cell_v[CELLS];
            vlane_reg <= {vlane_reg[LANE_STAGES-2:0], vraw_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg    <= ax;
        ay_reg    <= ay;
        side0_reg <= side_next;
        sqx_reg   <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
        sqy_reg   <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
        side1_reg <= side0_reg;
        sum_reg   <= sqx_reg + sqy_reg;
        side2_reg <= side1_reg;
    end

    // root cell chain
    always_comb
    begin
        cell_v[0]      = v2_reg;
        cell_d[0].rad  = sum_reg;
        cell_d[0].rem  = '0;
        cell_d[0].root = '0;
        cell_d[0].side = side2_reg;
    end

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        thrd_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cell_v[i]),
            .in_data   (cell_d[i]),
            .out_valid (cell_v[i+1]),
            .out_data  (cell_d[i+1])
        );
    end

    // motor select
    always_comb
    begin
        tail = cell_d[CELLS].side;
        yf   = tail.ys + RAW_W'(cfg_reg.bias);
        dg   = RAW_W'(cell_d[CELLS].root >> SCALE_SH);
        for (int m = 0; m < MOTORS; m++)
        begin
            raw_next[m] = '0;
        end
        if (tail.nz)
        begin
            case ({tail.yneg, tail.xneg})
                2'b10:
                begin
                    raw_next[0] = yf;
                    raw_next[1] = dg;
                    raw_next[2] = tail.xs;
                end
                2'b11:
                begin
                    raw_next[4] = yf;
                    raw_next[3] = dg;
                    raw_next[2] = tail.xs;
                end
                2'b01:
                begin
                    raw_next[4] = yf;
                    raw_next[5] = dg;
                    raw_next[6] = tail.xs;
                end
                default:
                begin
                    raw_next[0] = yf;
                    raw_next[7] = dg;
                    raw_next[6] = tail.xs;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg <= raw_next;
    end

    for (genvar m = 0; m < MOTORS; m++)
    begin : g_lane
        thrd_duty_lane u_lane (
            .clk  (clk),
            .raw  (raw_reg[m]),
            .cfg  (cfg_reg),
            .duty (duty[m])
        );
        assign nz_vec[m] = (duty[m] != '0);
    end

    assign done          = vlane_reg[LANE_STAGES-1];
    assign result.duty_0 = duty[0];
    assign result.duty_1 = duty[1];
    assign result.duty_2 = duty[2];
    assign result.duty_3 = duty[3];
    assign result.duty_4 = duty[4];
    assign result.duty_5 = duty[5];
    assign result.duty_6 = duty[6];
    assign result.duty_7 = duty[7];

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 23))
        else $error("result without a matching transaction");

    a_three_motors: assert property (@(posedge clk) disable iff (!rst_n)
        (done && cfg_reg.threshold != '0) |-> ($countones(nz_vec) <= 3))
        else $error("more than three motors driven");

    a_opposite_y: assert property (@(posedge clk) disable iff (!rst_n)
        (done && cfg_reg.threshold != '0) |-> !(nz_vec[0] && nz_vec[4]))
        else $error("opposite Y motors both driven");

endmodule
`default_nettype wire
